// ----- hw/rtl/fsp_pkg.sv -----
// Shared types, character codes and decode helpers for the format specifier parser.
// No dependencies; every other file of the block imports this package.
package fsp_pkg;

  // Digit runs saturate at 2^NUM_BITS-1 (range 8 to 31).
  localparam int unsigned NUM_BITS = 31;
  localparam logic [30:0] WIDTH_MAX = 31'((33'd1 << NUM_BITS) - 33'd1);

  // Multiply-by-ten accumulator width: 31-bit value times ten plus a digit.
  localparam int unsigned ACC_W = 35;

  // Stream widths (byte padded).
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 88;
  localparam int unsigned REC_W    = 81;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_H     = "h";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_BIG_L = "L";

  // Flag bit positions.
  localparam int unsigned F_PLUS  = 0;
  localparam int unsigned F_MINUS = 1;
  localparam int unsigned F_SPACE = 2;
  localparam int unsigned F_HASH  = 3;
  localparam int unsigned F_ZERO  = 4;

  // Length modifier codes.
  localparam logic [1:0] LEN_NONE   = 2'd0;
  localparam logic [1:0] LEN_SINGLE = 2'd1;
  localparam logic [1:0] LEN_DOUBLE = 2'd2;

  localparam logic signed [31:0] PREC_NONE = -32'sd1;

  typedef enum logic [2:0] {
    PH_TOP,
    PH_FLAGS,
    PH_WDIG,
    PH_AFTERW,
    PH_PDIG
  } phase_t;

  // Parser state carried between items.
  typedef struct packed {
    phase_t             phase;
    logic [4:0]         flags;
    logic [30:0]        width;
    logic signed [31:0] precision;
    logic [1:0]         short_len;
    logic [1:0]         long_len;
    logic               big_l;
    logic               short_la;
    logic               long_la;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_TOP,
    flags:     5'd0,
    width:     31'd0,
    precision: PREC_NONE,
    short_len: LEN_NONE,
    long_len:  LEN_NONE,
    big_l:     1'b0,
    short_la:  1'b0,
    long_la:   1'b0
  };

  // One result record, plus flag in the lowest bit.
  typedef struct packed {
    logic [7:0]         conversion;
    logic               long_double;
    logic [1:0]         long_len;
    logic [1:0]         short_len;
    logic signed [31:0] precision;
    logic [30:0]        field_width;
    logic               flag_zero;
    logic               flag_hash;
    logic               flag_space;
    logic               flag_minus;
    logic               flag_plus;
  } rec_t;

  // Mask of the flag that a character sets, zero if it is not a flag.
  function automatic logic [4:0] flag_mask(input logic [7:0] c);
    logic [4:0] m;
    m = 5'd0;
    case (c)
      CH_PLUS:  m[F_PLUS]  = 1'b1;
      CH_MINUS: m[F_MINUS] = 1'b1;
      CH_SPACE: m[F_SPACE] = 1'b1;
      CH_HASH:  m[F_HASH]  = 1'b1;
      CH_ZERO:  m[F_ZERO]  = 1'b1;
      default:  m = 5'd0;
    endcase
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_conv(input logic [7:0] c);
    logic r;
    case (c)
      "d", "i", "o", "u", "x", "X",
      "e", "E", "f", "F", "g", "G",
      "a", "A", "c", "s", "p", "n", "%": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/fsp_digit_acc.sv -----
// Saturating decimal accumulator: value times ten plus one digit.
// Depends on fsp_pkg for the saturation limit and accumulator width.
module fsp_digit_acc (
  input  logic [30:0] value,
  input  logic [3:0]  digit,
  output logic [30:0] result
);
  import fsp_pkg::*;

  logic [ACC_W-1:0] prod;

  // Ten times the value as a sum of two shifts, then the new digit.
  assign prod = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {31'd0, digit};

  // Clamp at the limit.
  assign result = (prod > {4'd0, WIDTH_MAX}) ? WIDTH_MAX : prod[30:0];

endmodule

// ----- hw/rtl/fsp_step.sv -----
// Next-state and record logic for one character of a format specifier.
// Depends on fsp_pkg and fsp_digit_acc.
module fsp_step (
  input  fsp_pkg::state_t     st,
  input  logic [7:0]          ch,
  input  logic signed [31:0]  star_arg,
  output fsp_pkg::state_t     nxt,
  output logic                emit,
  output fsp_pkg::rec_t       rec
);
  import fsp_pkg::*;

  logic [30:0] acc_in;
  logic [30:0] acc_out;
  logic [31:0] star_mag;
  logic [30:0] star_width;
  logic signed [31:0] star_prec;

  // The digit unit serves the precision run or the width run, never both at once.
  assign acc_in = (st.phase == PH_PDIG) ? st.precision[30:0] : st.width;

  fsp_digit_acc u_acc (
    .value  (acc_in),
    .digit  (ch[3:0]),
    .result (acc_out)
  );

  // Starred width: magnitude of the argument, saturated.
  assign star_mag   = star_arg[31] ? (~star_arg + 32'd1) : star_arg;
  assign star_width = (star_mag > {1'b0, WIDTH_MAX}) ? WIDTH_MAX : star_mag[30:0];

  // Starred precision: clamped to minus one below and to the limit above.
  always_comb begin
    if (star_arg < PREC_NONE) begin
      star_prec = PREC_NONE;
    end else if (star_arg > $signed({1'b0, WIDTH_MAX})) begin
      star_prec = $signed({1'b0, WIDTH_MAX});
    end else begin
      star_prec = star_arg;
    end
  end

  // Main decode for one character.
  always_comb begin
    state_t s;
    logic   done;
    s    = st;
    done = 1'b0;
    emit = 1'b0;
    rec  = '0;

    // Pending h or l decisions are settled by this character first.
    if (s.short_la) begin
      s.short_len = (ch == CH_H) ? LEN_DOUBLE : LEN_SINGLE;
      s.short_la  = 1'b0;
    end
    if (s.long_la) begin
      s.long_len = (ch == CH_L) ? LEN_DOUBLE : LEN_SINGLE;
      s.long_la  = 1'b0;
    end

    // Phase-specific handling; anything not consumed falls to the top level.
    case (s.phase)
      PH_FLAGS: begin
        if (flag_mask(ch) != 5'd0) begin
          s.flags = s.flags | flag_mask(ch);
          done    = 1'b1;
        end else begin
          // End of the flag run: minus beats zero, plus beats space.
          if (s.flags[F_MINUS]) s.flags[F_ZERO]  = 1'b0;
          if (s.flags[F_PLUS])  s.flags[F_SPACE] = 1'b0;
          s.phase = PH_TOP;
        end
      end
      PH_WDIG: begin
        if (is_digit(ch)) begin
          s.width = acc_out;
          done    = 1'b1;
        end else if (ch == CH_DOT) begin
          s.precision = 32'sd0;
          s.phase     = PH_PDIG;
          done        = 1'b1;
        end else begin
          s.phase = PH_TOP;
        end
      end
      PH_AFTERW: begin
        if (ch == CH_DOT) begin
          s.precision = 32'sd0;
          s.phase     = PH_PDIG;
          done        = 1'b1;
        end else begin
          s.phase = PH_TOP;
        end
      end
      PH_PDIG: begin
        if (is_digit(ch)) begin
          s.precision = $signed({1'b0, acc_out});
          done        = 1'b1;
        end else begin
          s.phase = PH_TOP;
          if (ch == CH_STAR) begin
            s.precision = star_prec;
            done        = 1'b1;
          end
        end
      end
      default: begin
        s.phase = PH_TOP;
      end
    endcase

    // Top-level dispatch.
    if (!done) begin
      if ((ch == CH_NUL) || is_conv(ch)) begin
        emit             = 1'b1;
        rec.flag_plus    = s.flags[F_PLUS];
        rec.flag_minus   = s.flags[F_MINUS];
        rec.flag_space   = s.flags[F_SPACE];
        rec.flag_hash    = s.flags[F_HASH];
        rec.flag_zero    = s.flags[F_ZERO];
        rec.field_width  = s.width;
        rec.precision    = s.precision;
        rec.short_len    = s.short_len;
        rec.long_len     = s.long_len;
        rec.long_double  = s.big_l;
        rec.conversion   = ch;
        s                = STATE_RESET;
      end else if (flag_mask(ch) != 5'd0) begin
        s.flags = s.flags | flag_mask(ch);
        s.phase = PH_FLAGS;
      end else if (is_digit(ch)) begin
        s.width = {27'd0, ch[3:0]};
        s.phase = PH_WDIG;
      end else if (ch == CH_DOT) begin
        s.precision = 32'sd0;
        s.phase     = PH_PDIG;
      end else if (ch == CH_STAR) begin
        // A negative starred width sets minus without the zero override.
        if (star_arg[31]) s.flags[F_MINUS] = 1'b1;
        s.width = star_width;
        s.phase = PH_AFTERW;
      end else if (ch == CH_H) begin
        if (s.short_len == LEN_NONE) s.short_la = 1'b1;
      end else if (ch == CH_L) begin
        if (s.long_len == LEN_NONE) s.long_la = 1'b1;
      end else if (ch == CH_BIG_L) begin
        s.big_l = 1'b1;
      end
    end

    nxt = s;
  end

endmodule

// ----- hw/rtl/format_spec_parser_top.sv -----
// Top level of the printf format specifier parser: stream ports, input and
// result registers and the parser state. Depends on fsp_pkg and fsp_step.
//
//  Channel | Direction | Handshake        | Contents
//  s_*     | in        | s_tvalid/tready  | one character after the percent sign
//  m_*     | out       | m_tvalid/tready  | one record per conversion char or NUL
//
// An item is decoded from the input register once the result register is free or being
// drained; its record, if any, is then registered and offered from the result register.
// One item per cycle is sustained while m_tready is high; the longest path is the
// multiply-by-ten accumulate. A synchronous reset empties both registers and returns
// the parser to the top level. While a record waits on m_tready the input register
// holds; s_tready drops only when both the input and the result registers are full.
module format_spec_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] ch, [39:8] star_arg
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // [0] flag_plus, [1] flag_minus, [2] flag_space,
                                 // [3] flag_hash, [4] flag_zero, [35:5] field_width,
                                 // [67:36] precision, [69:68] short_len,
                                 // [71:70] long_len, [72] long_double,
                                 // [80:73] conversion, [87:81] zero
);
  import fsp_pkg::*;

  logic               in_valid;
  logic [7:0]         in_ch;
  logic signed [31:0] in_arg;
  state_t             st;
  state_t             st_next;
  logic               emit;
  rec_t               rec;
  rec_t               out_rec;
  logic               out_valid;
  logic               step_go;

  // An item is decoded when the result register is free or being drained.
  assign step_go  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step_go;

  fsp_step u_step (
    .st       (st),
    .ch       (in_ch),
    .star_arg (in_arg),
    .nxt      (st_next),
    .emit     (emit),
    .rec      (rec)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= STATE_RESET;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (step_go) st <= st_next;
      if (step_go && emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch  <= s_tdata[7:0];
      in_arg <= $signed(s_tdata[39:8]);
    end
    if (step_go && emit) out_rec <= rec;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_rec};

endmodule

// ----- hw/rtl/fsp_checker.sv -----
// Port-level assertions for the format specifier parser, bound to the top level.
// Depends on fsp_pkg for the stream widths.
module fsp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [fsp_pkg::S_DATA_W-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fsp_pkg::M_DATA_W-1:0]  m_tdata
);
  import fsp_pkg::*;

  // No record is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("record offered after reset");

  // A stalled record stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("record withdrawn while stalled");

  // A stalled record keeps its contents.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("record changed while stalled");

  // With the result register empty the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no record pending");

  // Records carry legal length codes, a precision of at least minus one and zero padding.
  a_record_sane: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[69:68] != 2'b11) && (m_tdata[71:70] != 2'b11) &&
                 (!m_tdata[67] || (m_tdata[67:36] == 32'hFFFF_FFFF)) &&
                 (m_tdata[87:81] == 7'd0))
    else $error("malformed record");

endmodule

bind format_spec_parser_top fsp_checker u_fsp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for format_spec_parser_top: directed specifier strings, then random
// ones, records checked against an in-bench parser or by hand. Depends on fsp_pkg and the RTL.
module testbench;
  import fsp_pkg::*;

  localparam longint CAP = longint'(WIDTH_MAX);

  // One directed specifier: characters in body (zero bytes skipped), then the
  // terminating character. Where known is set, want is the record typed in by hand.
  typedef struct packed {
    logic [63:0] body;
    logic [7:0]  term;
    logic [31:0] arg;
    logic        known;
    rec_t        want;
  } spec_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  // Parser state as predicted by the bench.
  phase_t             pr_phase;
  logic [4:0]         pr_flags;
  logic [30:0]        pr_width;
  logic signed [31:0] pr_prec;
  logic [1:0]         pr_short;
  logic [1:0]         pr_long;
  logic               pr_big_l;
  logic               pr_short_la;
  logic               pr_long_la;

  rec_t  spec_q[$];
  int    fail_cnt = 0;
  int    sent_cnt = 0;
  string conv_set = "diouxXeEfFgGaAcspn%";
  string flag_set = " +-#0";
  string mod_set  = "hlL";

  format_spec_parser_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // Character decode, written independently of the package helpers.
  function automatic logic [4:0] char_flag(input logic [7:0] c);
    logic [4:0] m;
    m = 5'd0;
    case (c)
      CH_PLUS:  m[F_PLUS]  = 1'b1;
      CH_MINUS: m[F_MINUS] = 1'b1;
      CH_SPACE: m[F_SPACE] = 1'b1;
      CH_HASH:  m[F_HASH]  = 1'b1;
      CH_ZERO:  m[F_ZERO]  = 1'b1;
      default:  m = 5'd0;
    endcase
    return m;
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit conv_char(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < conv_set.len(); i++) begin
      if (conv_set[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  // Decimal accumulate with saturation at the largest width.
  function automatic logic [30:0] dec_acc(input logic [30:0] v, input logic [7:0] c);
    longint t;
    t = longint'(v) * 10 + longint'(c - CH_ZERO);
    return (t > CAP) ? WIDTH_MAX : t[30:0];
  endfunction

  function automatic rec_t spec_rec(input logic pl, input logic mi, input logic sp,
                                    input logic ha, input logic ze, input logic [30:0] w,
                                    input logic signed [31:0] p, input logic [1:0] sh,
                                    input logic [1:0] lg, input logic bl,
                                    input logic [7:0] cv);
    rec_t r;
    r.flag_plus   = pl;
    r.flag_minus  = mi;
    r.flag_space  = sp;
    r.flag_hash   = ha;
    r.flag_zero   = ze;
    r.field_width = w;
    r.precision   = p;
    r.short_len   = sh;
    r.long_len    = lg;
    r.long_double = bl;
    r.conversion  = cv;
    return r;
  endfunction

  task automatic clear_spec();
    pr_phase    = PH_TOP;
    pr_flags    = 5'd0;
    pr_width    = 31'd0;
    pr_prec     = PREC_NONE;
    pr_short    = LEN_NONE;
    pr_long     = LEN_NONE;
    pr_big_l    = 1'b0;
    pr_short_la = 1'b0;
    pr_long_la  = 1'b0;
  endtask

  // Advance the predicted parser by one character; queue a record when one is due.
  task automatic parse_char(input logic [7:0] c, input logic [31:0] a_raw);
    longint     sa;
    longint     mag;
    logic [4:0] fm;
    bit         go;
    sa = longint'($signed(a_raw));
    fm = char_flag(c);
    go = 1'b1;

    // Pending h/l decisions are settled before this character is handled.
    if (pr_short_la) begin
      pr_short    = (c == CH_H) ? LEN_DOUBLE : LEN_SINGLE;
      pr_short_la = 1'b0;
    end
    if (pr_long_la) begin
      pr_long    = (c == CH_L) ? LEN_DOUBLE : LEN_SINGLE;
      pr_long_la = 1'b0;
    end

    case (pr_phase)
      PH_FLAGS: begin
        if (fm != 5'd0) begin
          pr_flags |= fm;
          go = 1'b0;
        end else begin
          // End of a flag run: minus beats zero, plus beats space.
          if (pr_flags[F_MINUS]) pr_flags[F_ZERO] = 1'b0;
          if (pr_flags[F_PLUS]) pr_flags[F_SPACE] = 1'b0;
          pr_phase = PH_TOP;
        end
      end
      PH_WDIG: begin
        if (digit_char(c)) begin
          pr_width = dec_acc(pr_width, c);
          go = 1'b0;
        end else if (c == CH_DOT) begin
          pr_prec  = 32'sd0;
          pr_phase = PH_PDIG;
          go = 1'b0;
        end else begin
          pr_phase = PH_TOP;
        end
      end
      PH_AFTERW: begin
        if (c == CH_DOT) begin
          pr_prec  = 32'sd0;
          pr_phase = PH_PDIG;
          go = 1'b0;
        end else begin
          pr_phase = PH_TOP;
        end
      end
      PH_PDIG: begin
        if (digit_char(c)) begin
          pr_prec = {1'b0, dec_acc(pr_prec[30:0], c)};
          go = 1'b0;
        end else begin
          pr_phase = PH_TOP;
          if (c == CH_STAR) begin
            // A starred precision is clamped to [-1, largest width].
            if (sa < -1) sa = -1;
            if (sa > CAP) sa = CAP;
            pr_prec = sa[31:0];
            go = 1'b0;
          end
        end
      end
      default: pr_phase = PH_TOP;
    endcase

    if (go) begin
      if (c == CH_NUL || conv_char(c)) begin
        spec_q.push_back(spec_rec(pr_flags[F_PLUS], pr_flags[F_MINUS], pr_flags[F_SPACE],
                                  pr_flags[F_HASH], pr_flags[F_ZERO], pr_width, pr_prec,
                                  pr_short, pr_long, pr_big_l, c));
        clear_spec();
      end else if (fm != 5'd0) begin
        pr_flags |= fm;
        pr_phase = PH_FLAGS;
      end else if (digit_char(c)) begin
        pr_width = 31'(c - CH_ZERO);
        pr_phase = PH_WDIG;
      end else if (c == CH_DOT) begin
        pr_prec  = 32'sd0;
        pr_phase = PH_PDIG;
      end else if (c == CH_STAR) begin
        // A negative starred width means left-justify; its magnitude saturates.
        if (sa < 0) begin
          pr_flags[F_MINUS] = 1'b1;
          mag = -sa;
        end else begin
          mag = sa;
        end
        pr_width = (mag > CAP) ? WIDTH_MAX : mag[30:0];
        pr_phase = PH_AFTERW;
      end else if (c == CH_H) begin
        if (pr_short == LEN_NONE) pr_short_la = 1'b1;
      end else if (c == CH_L) begin
        if (pr_long == LEN_NONE) pr_long_la = 1'b1;
      end else if (c == CH_BIG_L) begin
        pr_big_l = 1'b1;
      end
    end
  endtask

  // Idle spells: runs of back-to-back items, otherwise a randomly drawn idle gap before each item.
  function automatic int draw_gap(input int n);
    return ((n % 100) < 25) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [31:0] rand_arg();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = -32'($urandom_range(1, 3));
      3:       v = 32'($urandom_range(0, 40));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Offer one item and hold it until the parser takes it.
  task automatic put_char(input logic [7:0] c, input logic [31:0] a);
    int gap;
    gap = draw_gap(sent_cnt);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {a, c};
    do @(posedge clk); while (!s_tready);
    parse_char(c, a);
    sent_cnt++;
  endtask

  task automatic put_digits(input bit lead_nonzero);
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && lead_nonzero) put_char(8'(CH_ZERO + $urandom_range(1, 9)), rand_arg());
      else put_char(8'(CH_ZERO + $urandom_range(0, 9)), rand_arg());
    end
  endtask

  // Stop offering items until every queued record has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (spec_q.size() != 0) @(posedge clk);
  endtask

  // One random specifier: mostly well formed, sometimes plain noise.
  task automatic send_random_spec();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) put_char(8'($urandom_range(0, 255)), rand_arg());
    end else begin
      n = $urandom_range(0, 4);
      repeat (n) put_char(flag_set[$urandom_range(0, 4)], rand_arg());
      case ($urandom_range(0, 3))
        1: put_digits(1'b1);
        2: put_char(CH_STAR, rand_arg());
        3: begin
          put_digits(1'b1);
          put_char(CH_STAR, rand_arg());
        end
        default: ;
      endcase
      if ($urandom_range(0, 1) == 1) begin
        put_char(CH_DOT, rand_arg());
        case ($urandom_range(0, 3))
          1: put_digits(1'b0);
          2: put_char(CH_STAR, rand_arg());
          3: begin
            put_digits(1'b0);
            put_char(CH_STAR, rand_arg());
          end
          default: ;
        endcase
      end
      case ($urandom_range(0, 7))
        2: put_char(CH_H, rand_arg());
        3: repeat (2) put_char(CH_H, rand_arg());
        4: put_char(CH_L, rand_arg());
        5: repeat (2) put_char(CH_L, rand_arg());
        6: put_char(CH_BIG_L, rand_arg());
        7: begin
          n = $urandom_range(1, 4);
          repeat (n) put_char(mod_set[$urandom_range(0, 2)], rand_arg());
        end
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) put_char(8'($urandom_range(0, 255)), rand_arg());
      if ($urandom_range(0, 19) == 0) put_char(CH_NUL, rand_arg());
      else put_char(conv_set[$urandom_range(0, 18)], rand_arg());
    end
  endtask

  // Reset, directed table, random specifiers, then drain and report.
  initial begin : stimulus
    spec_row_t dir_rows[9];
    int        base;
    bit        paused;
    dir_rows[0] = '{{32'd0, 8'hff, "hlh"}, "d", 32'd0, 1'b1,
                    spec_rec(0, 0, 0, 0, 0, 31'd0, PREC_NONE, LEN_SINGLE, LEN_SINGLE, 0, "d")};
    dir_rows[1] = '{64'("-0+ #"), "i", 32'd0, 1'b1,
                    spec_rec(1, 1, 0, 1, 0, 31'd0, PREC_NONE, LEN_NONE, LEN_NONE, 0, "i")};
    dir_rows[2] = '{64'("*"), "d", 32'h8000_0000, 1'b1,
                    spec_rec(0, 1, 0, 0, 0, WIDTH_MAX, PREC_NONE, LEN_NONE, LEN_NONE, 0, "d")};
    dir_rows[3] = '{64'("0*"), "u", -32'sd5, 1'b1,
                    spec_rec(0, 1, 0, 0, 1, 31'd5, PREC_NONE, LEN_NONE, LEN_NONE, 0, "u")};
    dir_rows[4] = '{64'(".*"), "e", 32'h7fff_ffff, 1'b1,
                    spec_rec(0, 0, 0, 0, 0, 31'd0, 32'sh7fff_ffff, LEN_NONE, LEN_NONE, 0, "e")};
    dir_rows[5] = '{64'("5.3+"), CH_NUL, 32'd0, 1'b0, '0};
    dir_rows[6] = '{64'("hhllL"), "d", 32'd0, 1'b0, '0};
    dir_rows[7] = '{64'("3 7.5*"), "s", -32'sd9, 1'b0, '0};
    dir_rows[8] = '{64'd0, "%", 32'd0, 1'b1,
                    spec_rec(0, 0, 0, 0, 0, 31'd0, PREC_NONE, LEN_NONE, LEN_NONE, 0, "%")};
    paused = 1'b0;
    clear_spec();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      for (int b = 7; b >= 0; b--) begin
        if (dir_rows[i].body[8*b +: 8] != 8'h00) begin
          put_char(dir_rows[i].body[8*b +: 8], dir_rows[i].arg);
        end
      end
      put_char(dir_rows[i].term, dir_rows[i].arg);
      if (dir_rows[i].known) spec_q[spec_q.size() - 1] = dir_rows[i].want;
    end
    wait_drained();

    base = sent_cnt;
    while (sent_cnt < base + 450) begin
      send_random_spec();
      if (!paused && sent_cnt > base + 220) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Record acceptance with random stalls and one long hold-off that backs up the input.
  initial begin : record_sink
    int gap;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(taken);
      if (!held && taken == 30) begin
        gap  = 250;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Compare each accepted record with the oldest one predicted.
  always @(posedge clk) begin : record_check
    rec_t got;
    rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = rec_t'(m_tdata[REC_W-1:0]);
      if (spec_q.size() == 0) begin
        $error("record with none predicted: conversion %0d", got.conversion);
        fail_cnt++;
      end else begin
        want = spec_q.pop_front();
        cmp_field("flag_plus", want.flag_plus, got.flag_plus);
        cmp_field("flag_minus", want.flag_minus, got.flag_minus);
        cmp_field("flag_space", want.flag_space, got.flag_space);
        cmp_field("flag_hash", want.flag_hash, got.flag_hash);
        cmp_field("flag_zero", want.flag_zero, got.flag_zero);
        cmp_field("field_width", want.field_width, got.field_width);
        cmp_field("precision", longint'($signed(want.precision)),
                  longint'($signed(got.precision)));
        cmp_field("short_len", want.short_len, got.short_len);
        cmp_field("long_len", want.long_len, got.long_len);
        cmp_field("long_double", want.long_double, got.long_double);
        cmp_field("conversion", want.conversion, got.conversion);
      end
    end
  end

endmodule

// ----- sim.f -----
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_digit_acc.sv
hw/rtl/fsp_step.sv
hw/rtl/format_spec_parser_top.sv
hw/rtl/fsp_checker.sv
sim/testbench.sv
